// File: src/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
// No dependencies; imported by the block cell and the top level.
package ffha_pkg;

  localparam int unsigned REQ_W   = 21;
  localparam int unsigned ADDR_W  = 20;
  localparam int unsigned TOTAL_W = 23;
  localparam int unsigned ALIGN_MASK    = 7;
  localparam int unsigned MIN_REMAINDER = 32;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DISABLED = 2'd1;
  localparam logic [1:0] ST_NOMEM    = 2'd2;
  localparam logic [1:0] ST_BADFREE  = 2'd3;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_MARK,
    CMD_INSERT,
    CMD_REMOVE
  } cell_kind_e;

  typedef struct packed {
    cell_kind_e kind;
    logic       used;
  } cell_cmd_t;

endpackage

// File: src/ffha_cell.sv
// One entry of the address-ordered block table, a link in the cell chain.
// Depends on ffha_pkg; instantiated by first_fit_heap_allocator.
module ffha_cell import ffha_pkg::*; #(
  parameter int unsigned INDEX        = 0,
  parameter int unsigned IW           = 6,
  parameter int unsigned AW           = 20,
  parameter int unsigned SW           = 21,
  parameter int unsigned HEAP_BYTES   = 1048576,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_cmd_t          cmd_i,
  input  logic [IW-1:0]      pos_i,
  input  logic [AW-1:0]      cmd_start_i,
  input  logic [SW-1:0]      cmd_size_i,
  input  logic [AW-1:0]      left_start_i,
  input  logic [SW-1:0]      left_size_i,
  input  logic               left_used_i,
  input  logic [AW-1:0]      right_start_i,
  input  logic [SW-1:0]      right_size_i,
  input  logic               right_used_i,
  input  logic               op_i,
  input  logic [TOTAL_W-1:0] total_i,
  input  logic [ADDR_W-1:0]  addr_i,
  output logic [AW-1:0]      start_o,
  output logic [SW-1:0]      size_o,
  output logic               used_o,
  output logic               hit_o
);

  localparam int unsigned CW = ((SW > TOTAL_W) ? SW : TOTAL_W) + 1;
  localparam int unsigned FW = AW + 8;
  localparam logic [IW-1:0] MY_POS = IW'(INDEX);
  localparam logic [SW-1:0] RST_SIZE = (INDEX == 0) ? SW'(HEAP_BYTES) : '0;

  logic [AW-1:0] start_q, start_d;
  logic [SW-1:0] size_q, size_d;
  logic          used_q, used_d;
  logic          here, after;

  assign here  = (pos_i == MY_POS);
  assign after = (MY_POS > pos_i);

  always_comb begin
    start_d = start_q;
    size_d  = size_q;
    used_d  = used_q;
    case (cmd_i.kind)
      CMD_MARK: begin
        if (here) begin
          size_d = cmd_size_i;
          used_d = cmd_i.used;
        end
      end
      CMD_INSERT: begin
        if (here) begin
          start_d = cmd_start_i;
          size_d  = cmd_size_i;
          used_d  = 1'b0;
        end else if (after) begin
          start_d = left_start_i;
          size_d  = left_size_i;
          used_d  = left_used_i;
        end
      end
      CMD_REMOVE: begin
        if (here || after) begin
          start_d = right_start_i;
          size_d  = right_size_i;
          used_d  = right_used_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      size_q  <= RST_SIZE;
      used_q  <= 1'b0;
    end else begin
      start_q <= start_d;
      size_q  <= size_d;
      used_q  <= used_d;
    end
  end

  // Entries past the live count hold zero size and are never used, so they never hit.
  always_comb begin
    if (op_i == OP_ALLOC) begin
      hit_o = !used_q && (CW'(size_q) >= CW'(total_i));
    end else begin
      hit_o = used_q && ((FW'(start_q) + FW'(HEADER_BYTES)) == FW'(addr_i));
    end
  end

  assign start_o = start_q;
  assign size_o  = size_q;
  assign used_o  = used_q;

endmodule

// File: src/first_fit_heap_allocator.sv
// First-fit heap allocator: top level with the request sequencer.
// Depends on ffha_pkg and ffha_cell.
//
// Usage: a request beat (op_i, req_size_i, free_addr_i) is taken when
// in_valid_i is high and in_stall_o is low. Each request gives exactly one
// result beat (payload_addr_o, status_o), delivered when out_valid_o is high
// and out_stall_i is low. Requests are handled one at a time; in_stall_o is
// high from acceptance until the result is loaded into the output register.
// A rejected allocate (disabled or zero size) skips the search. Otherwise
// all cells are searched in parallel, then the table is edited one step at
// a time, each edit shifting the whole chain of cells by at most one place.
// The result register keeps its beat while out_stall_i is high, and the next
// request may already be taken and worked on meanwhile; its result waits.
// cfg_ready_o is always high; heap_enable is written with cfg_valid_i and
// should only change while no request is in flight.
// Reset leaves one free block spanning the whole heap and heap_enable set.
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int unsigned HEAP_BYTES   = 1048576,
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_heap_enable_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              op_i,
  input  logic [REQ_W-1:0]  req_size_i,
  input  logic [ADDR_W-1:0] free_addr_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [ADDR_W-1:0] payload_addr_o,
  output logic [1:0]        status_o
);

  localparam int unsigned AW  = $clog2(HEAP_BYTES);
  localparam int unsigned SW  = $clog2(HEAP_BYTES + 1);
  localparam int unsigned IW  = $clog2(MAX_BLOCKS);
  localparam int unsigned CNW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CW  = ((SW > TOTAL_W) ? SW : TOTAL_W) + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_EXEC, S_INS, S_NXT, S_REM, S_PRV, S_REM2, S_DONE
  } state_e;

  state_e             state_q, state_d;
  logic               op_q, op_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic               found_q, found_d;
  logic [SW-1:0]      cur_size_q, cur_size_d;
  logic [AW-1:0]      ins_start_q, ins_start_d;
  logic [SW-1:0]      ins_size_q, ins_size_d;
  logic [CNW-1:0]     count_q, count_d;
  logic               enable_q;
  logic [ADDR_W-1:0]  res_addr_q, res_addr_d;
  logic [1:0]         res_status_q, res_status_d;
  logic               out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]  out_addr_q, out_addr_d;
  logic [1:0]         out_status_q, out_status_d;

  cell_cmd_t          cmd;
  logic [IW-1:0]      pos;
  logic [AW-1:0]      cmd_start;
  logic [SW-1:0]      cmd_size;

  logic [AW-1:0]      c_start [MAX_BLOCKS];
  logic [SW-1:0]      c_size  [MAX_BLOCKS];
  logic               c_used  [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] hit;

  logic [IW-1:0]      first_idx;
  logic [IW-1:0]      rd_idx;
  logic [AW-1:0]      rd_start;
  logic [SW-1:0]      rd_size;
  logic               rd_used;
  logic [TOTAL_W-1:0] req_total;
  logic               next_live;

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    logic [AW-1:0] l_start, r_start;
    logic [SW-1:0] l_size, r_size;
    logic          l_used, r_used;
    if (k == 0) begin : g_first
      assign l_start = '0;
      assign l_size  = '0;
      assign l_used  = 1'b0;
    end else begin : g_mid
      assign l_start = c_start[k-1];
      assign l_size  = c_size[k-1];
      assign l_used  = c_used[k-1];
    end
    if (k == MAX_BLOCKS - 1) begin : g_last
      assign r_start = '0;
      assign r_size  = '0;
      assign r_used  = 1'b0;
    end else begin : g_inner
      assign r_start = c_start[k+1];
      assign r_size  = c_size[k+1];
      assign r_used  = c_used[k+1];
    end
    ffha_cell #(
      .INDEX(k), .IW(IW), .AW(AW), .SW(SW),
      .HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES)
    ) u_cell (
      .clk_i, .rst_ni,
      .cmd_i(cmd), .pos_i(pos), .cmd_start_i(cmd_start), .cmd_size_i(cmd_size),
      .left_start_i(l_start), .left_size_i(l_size), .left_used_i(l_used),
      .right_start_i(r_start), .right_size_i(r_size), .right_used_i(r_used),
      .op_i(op_q), .total_i(total_q), .addr_i(addr_q),
      .start_o(c_start[k]), .size_o(c_size[k]), .used_o(c_used[k]), .hit_o(hit[k])
    );
  end

  always_comb begin
    first_idx = '0;
    for (int k = MAX_BLOCKS - 1; k >= 0; k--) begin
      if (hit[k]) first_idx = IW'(k);
    end
  end

  always_comb begin
    case (state_q)
      S_NXT:   rd_idx = idx_q + IW'(1);
      S_PRV:   rd_idx = idx_q - IW'(1);
      default: rd_idx = idx_q;
    endcase
  end

  assign rd_start  = c_start[rd_idx];
  assign rd_size   = c_size[rd_idx];
  assign rd_used   = c_used[rd_idx];
  assign req_total = ((TOTAL_W'(req_size_i) + TOTAL_W'(ALIGN_MASK)) & ~TOTAL_W'(ALIGN_MASK))
                     + TOTAL_W'(HEADER_BYTES);
  assign next_live = (CNW'(idx_q) + CNW'(1)) < count_q;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    total_d      = total_q;
    addr_d       = addr_q;
    idx_d        = idx_q;
    found_d      = found_q;
    cur_size_d   = cur_size_q;
    ins_start_d  = ins_start_q;
    ins_size_d   = ins_size_q;
    count_d      = count_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_addr_d   = out_addr_q;
    out_status_d = out_status_q;
    cmd          = '{kind: CMD_NONE, used: 1'b0};
    pos          = idx_q;
    cmd_start    = ins_start_q;
    cmd_size     = rd_size;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d       = op_i;
          total_d    = req_total;
          addr_d     = free_addr_i;
          res_addr_d = '0;
          if (op_i == OP_ALLOC && (!enable_q || req_size_i == '0)) begin
            res_status_d = ST_DISABLED;
            state_d      = S_DONE;
          end else begin
            state_d = S_FIND;
          end
        end
      end
      S_FIND: begin
        idx_d   = first_idx;
        found_d = |hit;
        state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!found_q) begin
          res_status_d = (op_q == OP_ALLOC) ? ST_NOMEM : ST_BADFREE;
          state_d      = S_DONE;
        end else if (op_q == OP_ALLOC) begin
          res_status_d = ST_OK;
          res_addr_d   = ADDR_W'(CW'(rd_start) + CW'(HEADER_BYTES));
          cmd          = '{kind: CMD_MARK, used: 1'b1};
          if (CW'(rd_size) >= CW'(total_q) + CW'(HEADER_BYTES) + CW'(MIN_REMAINDER)
              && count_q < CNW'(MAX_BLOCKS)) begin
            cmd_size    = SW'(total_q);
            ins_start_d = AW'(CW'(rd_start) + CW'(total_q));
            ins_size_d  = SW'(CW'(rd_size) - CW'(total_q));
            state_d     = S_INS;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          res_status_d = ST_OK;
          cmd          = '{kind: CMD_MARK, used: 1'b0};
          cur_size_d   = rd_size;
          state_d      = S_NXT;
        end
      end
      S_INS: begin
        cmd       = '{kind: CMD_INSERT, used: 1'b0};
        pos       = idx_q + IW'(1);
        cmd_size  = ins_size_q;
        count_d   = count_q + CNW'(1);
        state_d   = S_DONE;
      end
      S_NXT: begin
        if (next_live && !rd_used) begin
          cmd        = '{kind: CMD_MARK, used: 1'b0};
          cmd_size   = cur_size_q + rd_size;
          cur_size_d = cur_size_q + rd_size;
          state_d    = S_REM;
        end else begin
          state_d = S_PRV;
        end
      end
      S_REM: begin
        cmd     = '{kind: CMD_REMOVE, used: 1'b0};
        pos     = idx_q + IW'(1);
        count_d = count_q - CNW'(1);
        state_d = S_PRV;
      end
      S_PRV: begin
        if (idx_q != '0 && !rd_used) begin
          cmd      = '{kind: CMD_MARK, used: 1'b0};
          pos      = idx_q - IW'(1);
          cmd_size = rd_size + cur_size_q;
          state_d  = S_REM2;
        end else begin
          state_d = S_DONE;
        end
      end
      S_REM2: begin
        cmd     = '{kind: CMD_REMOVE, used: 1'b0};
        count_d = count_q - CNW'(1);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_addr_d   = res_addr_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= CNW'(1);
      enable_q     <= 1'b1;
      out_valid_q  <= 1'b0;
      found_q      <= 1'b0;
      op_q         <= OP_ALLOC;
      total_q      <= '0;
      addr_q       <= '0;
      idx_q        <= '0;
      cur_size_q   <= '0;
      ins_start_q  <= '0;
      ins_size_q   <= '0;
      res_addr_q   <= '0;
      res_status_q <= ST_OK;
      out_addr_q   <= '0;
      out_status_q <= ST_OK;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      found_q      <= found_d;
      if (cfg_valid_i) enable_q <= cfg_heap_enable_i;
      op_q         <= op_d;
      total_q      <= total_d;
      addr_q       <= addr_d;
      idx_q        <= idx_d;
      cur_size_q   <= cur_size_d;
      ins_start_q  <= ins_start_d;
      ins_size_q   <= ins_size_d;
      res_addr_q   <= res_addr_d;
      res_status_q <= res_status_d;
      out_addr_q   <= out_addr_d;
      out_status_q <= out_status_d;
    end
  end

  assign cfg_ready_o    = 1'b1;
  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign payload_addr_o = out_addr_q;
  assign status_o       = out_status_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CNW'(1) && count_q <= CNW'(MAX_BLOCKS))
    else $error("block count out of range");

  a_fail_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> payload_addr_o == '0)
    else $error("failed result carries a nonzero address");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REM || state_q == S_REM2) |=> count_q == $past(count_q) - CNW'(1))
    else $error("merge did not shrink the table");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS) |=> count_q == $past(count_q) + CNW'(1))
    else $error("split did not grow the table");

endmodule

// File: tb/ffha_checker.sv
// Checker for the first-fit heap allocator: mirrors the block table, predicts
// each result beat and compares it with what the block delivers.
// Depends on ffha_pkg.
`timescale 1ns / 100ps

module ffha_checker import ffha_pkg::*; #(
  parameter int unsigned HEAP_BYTES   = 1048576,
  parameter int unsigned MAX_BLOCKS   = 64,
  parameter int unsigned HEADER_BYTES = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic              cfg_heap_enable_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic              op_i,
  input  logic [REQ_W-1:0]  req_size_i,
  input  logic [ADDR_W-1:0] free_addr_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [ADDR_W-1:0] payload_addr_i,
  input  logic [1:0]        status_i,
  output int                errors_o,
  output int                pending_o
);

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [1:0]        status;
  } alloc_result_t;

  longint unsigned blk_start [MAX_BLOCKS];
  longint unsigned blk_size  [MAX_BLOCKS];
  bit              blk_used  [MAX_BLOCKS];
  int unsigned     blk_count;
  bit              enable_q;
  alloc_result_t   result_q [$];

  function automatic void drop_block(int unsigned idx);
    for (int unsigned k = idx; k + 1 < blk_count; k++) begin
      blk_start[k] = blk_start[k+1];
      blk_size[k]  = blk_size[k+1];
      blk_used[k]  = blk_used[k+1];
    end
    blk_count--;
    blk_start[blk_count] = 0;
    blk_size[blk_count]  = 0;
    blk_used[blk_count]  = 0;
  endfunction

  function automatic alloc_result_t heap_predict(logic op, logic [REQ_W-1:0] req,
                                                 logic [ADDR_W-1:0] addr);
    alloc_result_t   res;
    longint unsigned total;
    int unsigned     i;
    res = '0;
    if (op == OP_ALLOC) begin
      if (!enable_q || req == 0) begin
        res.status = ST_DISABLED;
        return res;
      end
      total = ((longint'(req) + ALIGN_MASK) & ~longint'(ALIGN_MASK)) + HEADER_BYTES;
      for (i = 0; i < blk_count; i++)
        if (!blk_used[i] && blk_size[i] >= total) break;
      if (i >= blk_count) begin
        res.status = ST_NOMEM;
        return res;
      end
      // Split only when a usable remainder is left and the table has room.
      if (blk_size[i] >= total + HEADER_BYTES + MIN_REMAINDER && blk_count < MAX_BLOCKS) begin
        for (int unsigned k = blk_count; k > i + 1; k--) begin
          blk_start[k] = blk_start[k-1];
          blk_size[k]  = blk_size[k-1];
          blk_used[k]  = blk_used[k-1];
        end
        blk_start[i+1] = blk_start[i] + total;
        blk_size[i+1]  = blk_size[i] - total;
        blk_used[i+1]  = 0;
        blk_count++;
        blk_size[i] = total;
      end
      blk_used[i] = 1;
      res.addr   = ADDR_W'(blk_start[i] + HEADER_BYTES);
      res.status = ST_OK;
    end else begin
      for (i = 0; i < blk_count; i++)
        if (blk_used[i] && blk_start[i] + HEADER_BYTES == longint'(addr)) break;
      if (i >= blk_count) begin
        res.status = ST_BADFREE;
        return res;
      end
      blk_used[i] = 0;
      if (i + 1 < blk_count && !blk_used[i+1]) begin
        blk_size[i] += blk_size[i+1];
        drop_block(i + 1);
      end
      if (i > 0 && !blk_used[i-1]) begin
        blk_size[i-1] += blk_size[i];
        drop_block(i);
      end
      res.status = ST_OK;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    if (!rst_ni) begin
      for (int k = 0; k < MAX_BLOCKS; k++) begin
        blk_start[k] = 0;
        blk_size[k]  = 0;
        blk_used[k]  = 0;
      end
      blk_size[0] = HEAP_BYTES;
      blk_count   = 1;
      enable_q    = 1;
      result_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) enable_q = cfg_heap_enable_i;
      if (in_valid_i && !in_stall_i)
        result_q.push_back(heap_predict(op_i, req_size_i, free_addr_i));
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          if (errors_o < 10)
            $display("unexpected result beat: addr=%0d status=%0d", payload_addr_i, status_i);
          errors_o <= errors_o + 1;
        end else begin
          want = result_q.pop_front();
          if (want.addr !== payload_addr_i || want.status !== status_i) begin
            if (errors_o < 10)
              $display("mismatch: expected addr=%0d status=%0d, got addr=%0d status=%0d",
                       want.addr, want.status, payload_addr_i, status_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      pending_o <= result_q.size();
    end
  end

endmodule

// File: tb/tb_first_fit_heap_allocator.sv
// Testbench top for the first-fit heap allocator: drives requests, config
// writes and output stalls, and gives the verdict from ffha_checker.
// Depends on ffha_pkg, first_fit_heap_allocator and ffha_checker.
`timescale 1ns / 100ps

module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic              clk_i = 0;
  logic              rst_ni = 0;
  logic              cfg_valid_i = 0;
  logic              cfg_ready_o;
  logic              cfg_heap_enable_i = 1;
  logic              in_valid_i = 0;
  logic              in_stall_o;
  logic              op_i = OP_ALLOC;
  logic [REQ_W-1:0]  req_size_i = '0;
  logic [ADDR_W-1:0] free_addr_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 0;
  logic [ADDR_W-1:0] payload_addr_o;
  logic [1:0]        status_o;
  int                errors;
  int                pending;
  int                cycles = 0;
  bit                stall_quiet = 0;
  logic [ADDR_W-1:0] live_addrs [$];

  first_fit_heap_allocator uut (.*);

  ffha_checker u_checker (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_heap_enable_i,
    .in_valid_i, .in_stall_i(in_stall_o), .op_i, .req_size_i, .free_addr_i,
    .out_valid_i(out_valid_o), .out_stall_i, .payload_addr_i(payload_addr_o),
    .status_i(status_o), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Count cycles and stop at the limit; remember payload offsets of successful allocations for later frees.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_ni && out_valid_o && !out_stall_i && status_o == ST_OK && payload_addr_o != 0)
      live_addrs.push_back(payload_addr_o);
  end

  always @(posedge clk_i) begin
    if (stall_quiet) out_stall_i <= 0;
    else out_stall_i <= (pick_gap() > 0);
  end

  task automatic send_req(logic op, logic [REQ_W-1:0] size, logic [ADDR_W-1:0] addr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1;
    op_i        <= op;
    req_size_i  <= size;
    free_addr_i <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_enable(logic value);
    cfg_valid_i       <= 1;
    cfg_heap_enable_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
  endtask

  task automatic random_req();
    int r, idx;
    logic [REQ_W-1:0] size;
    r = $urandom_range(0, 99);
    if (r < 48) begin
      case ($urandom_range(0, 19))
        0:       size = 0;
        1:       size = $urandom_range(0, (1 << REQ_W) - 1);
        2:       size = $urandom_range(65536, 1048576);
        3, 4:    size = $urandom_range(4097, 40000);
        default: size = $urandom_range(1, 4096);
      endcase
      send_req(OP_ALLOC, size, ADDR_W'($urandom));
    end else if (r < 88 && live_addrs.size() > 0) begin
      idx = $urandom_range(0, live_addrs.size() - 1);
      send_req(OP_FREE, REQ_W'($urandom), live_addrs[idx]);
      live_addrs.delete(idx);
    end else begin
      send_req(OP_FREE, REQ_W'($urandom), ADDR_W'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Rounding, exact fit, zero size, oversize, bad and double frees.
    send_req(OP_ALLOC, 0, 0);
    send_req(OP_ALLOC, 1, 0);
    send_req(OP_ALLOC, 8, 0);
    send_req(OP_ALLOC, 9, '1);
    send_req(OP_ALLOC, 1048576, 0);
    send_req(OP_ALLOC, '1, 0);
    send_req(OP_FREE, 0, 0);
    send_req(OP_FREE, 0, 20'd57);
    send_req(OP_FREE, '1, 20'd56);
    send_req(OP_FREE, 0, 20'd56);
    send_req(OP_FREE, 0, 20'd24);
    send_req(OP_FREE, 0, 20'd88);
    send_req(OP_ALLOC, 1048552, 0);
    send_req(OP_ALLOC, 1, 0);
    send_req(OP_FREE, 0, 20'd24);
    send_req(OP_FREE, 0, '1);
    wait_idle();
    live_addrs.delete();

    write_enable(0);
    send_req(OP_ALLOC, 100, 0);
    send_req(OP_ALLOC, 0, 0);
    send_req(OP_FREE, 0, 20'd24);
    wait_idle();
    write_enable(1);

    for (int n = 0; n < 500; n++) begin
      stall_quiet = (n >= 200 && n < 260);
      if (n == 300) begin
        wait_idle();
        write_enable(0);
      end
      if (n == 330) begin
        wait_idle();
        write_enable(1);
      end
      random_req();
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
